[design/bqf_pkg.sv]
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared constants and types for the multichannel biquad filter core.
// ----------------------------------------------------------------------------
package bqf_pkg;

  localparam int CHANNELS_DEF       = 8;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 24;

  localparam int COEF_W    = 32;
  localparam int HIST_W    = 32;
  localparam int CHAN_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_COEFS = 5;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [HIST_W-1:0] hist_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

endpackage

[design/bqf_ram.sv]
// ----------------------------------------------------------------------------
// bqf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bqf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/bqf_datapath.sv]
// ----------------------------------------------------------------------------
// bqf_datapath
// Five-tap multiply-accumulate with round-to-nearest and dual saturation.
// ----------------------------------------------------------------------------
module bqf_datapath
  import bqf_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  coef_set_t                      coefs,
  input  logic signed [SAMPLE_BITS-1:0]  x,
  input  logic signed [SAMPLE_BITS-1:0]  x1,
  input  logic signed [SAMPLE_BITS-1:0]  x2,
  input  hist_t                          y1,
  input  hist_t                          y2,
  output hist_t                          y_hist,
  output logic signed [SAMPLE_BITS-1:0]  y_sample
);

  localparam int ACC_W = COEF_W + HIST_W + 3;
  localparam int PX_W  = COEF_W + SAMPLE_BITS;
  localparam int PY_W  = COEF_W + HIST_W;
  localparam int Y_W   = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [Y_W-1:0] H_MAX = Y_W'((longint'(1) << (HIST_W - 1)) - 1);
  localparam logic signed [Y_W-1:0] H_MIN = -H_MAX - Y_W'(1);
  localparam logic signed [Y_W-1:0] S_MAX = Y_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Y_W-1:0] S_MIN = -S_MAX - Y_W'(1);

  logic signed [PX_W-1:0]  p0, p1, p2;
  logic signed [PY_W-1:0]  p3, p4;
  logic signed [ACC_W-1:0] e0, e1, e2, e3, e4;
  logic signed [ACC_W-1:0] acc;
  logic signed [Y_W-1:0]   y;

  assign p0 = coefs.b0 * x;
  assign p1 = coefs.b1 * x1;
  assign p2 = coefs.b2 * x2;
  assign p3 = coefs.a1 * y1;
  assign p4 = coefs.a2 * y2;

  assign e0 = ACC_W'(p0);
  assign e1 = ACC_W'(p1);
  assign e2 = ACC_W'(p2);
  assign e3 = ACC_W'(p3);
  assign e4 = ACC_W'(p4);

  assign acc = e0 + e1 + e2 - e3 - e4 + RND;
  assign y   = acc[ACC_W-1:COEF_FRAC_BITS];

  always_comb begin
    if (y > H_MAX) begin
      y_hist = HIST_W'(H_MAX);
    end else if (y < H_MIN) begin
      y_hist = HIST_W'(H_MIN);
    end else begin
      y_hist = y[HIST_W-1:0];
    end
    if (y > S_MAX) begin
      y_sample = SAMPLE_BITS'(S_MAX);
    end else if (y < S_MIN) begin
      y_sample = SAMPLE_BITS'(S_MIN);
    end else begin
      y_sample = y[SAMPLE_BITS-1:0];
    end
  end

endmodule

[design/biquad_filter_multichannel_core.sv]
// ----------------------------------------------------------------------------
// biquad_filter_multichannel_core
// Direct form I biquad with a separate history for each channel.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_ready   in_channel, in_sample_in
//  out_     output     out_valid / out_ready out_sample_out, out_channel
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One transaction per cycle unless the output stalls; an accepted item passes
// through the input register, then the output register. The channel history is
// read from RAM at acceptance and written back when the item moves to the
// output register; a same-channel follower is bypassed. Reset and any
// coefficient write clear every history through valid bits. A stalled output
// holds the input register; input is taken while either stage can advance.
// ----------------------------------------------------------------------------
module biquad_filter_multichannel_core
  import bqf_pkg::*;
#(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CHAN_W-1:0]             in_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic [CHAN_W-1:0]             out_channel,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_wdata
);

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HWORD  = 2 * SAMPLE_BITS + 2 * HIST_W;
  localparam logic [CHAN_W-1:0] CH_STEP = CHAN_W'(CHANNELS);
  localparam coef_t B0_RESET = COEF_W'(longint'(1) << COEF_FRAC_BITS);

  coef_set_t coef_r;
  logic [CHANNELS-1:0] hv_valid_r;

  logic                          s1_valid_r;
  logic [CHAN_W-1:0]             s1_chan_r;
  logic [IDX_W-1:0]              s1_idx_r;
  logic signed [SAMPLE_BITS-1:0] s1_x_r;
  logic                          s1_byp_r;
  logic [HWORD-1:0]              s1_bypd_r;
  logic                          s1_hv_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [CHAN_W-1:0]             out_channel_r;

  logic [CHAN_W-1:0]             in_mod;
  logic [IDX_W-1:0]              in_idx;
  logic                          in_acc;
  logic                          s1_adv;
  logic                          coef_wr;
  logic [HWORD-1:0]              ram_rd;
  logic [HWORD-1:0]              hist_cur;
  logic [HWORD-1:0]              hist_new;
  logic signed [SAMPLE_BITS-1:0] h_x1, h_x2;
  hist_t                         h_y1, h_y2;
  hist_t                         y_hist;
  logic signed [SAMPLE_BITS-1:0] y_sample;

  always_comb begin
    in_mod = in_channel;
    for (int k = 0; k < 7; k++) begin
      if (32'(in_mod) >= CHANNELS) begin
        in_mod = in_mod - CH_STEP;
      end
    end
  end

  assign in_idx   = IDX_W'(in_mod);
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign coef_wr  = cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEFS));

  always_comb begin
    if (s1_byp_r) begin
      hist_cur = s1_bypd_r;
    end else if (s1_hv_r) begin
      hist_cur = ram_rd;
    end else begin
      hist_cur = '0;
    end
  end

  assign {h_x1, h_x2, h_y1, h_y2} = hist_cur;
  assign hist_new = {s1_x_r, h_x1, y_hist, h_y1};

  bqf_ram #(
    .WIDTH (HWORD),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx_r),
    .wdata (hist_new),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (ram_rd)
  );

  bqf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .coefs    (coef_r),
    .x        (s1_x_r),
    .x1       (h_x1),
    .x2       (h_x2),
    .y1       (h_y1),
    .y2       (h_y2),
    .y_hist   (y_hist),
    .y_sample (y_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= B0_RESET;
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:  coef_r.b0 <= cfg_wdata;
        REG_B1:  coef_r.b1 <= cfg_wdata;
        REG_B2:  coef_r.b2 <= cfg_wdata;
        REG_A1:  coef_r.a1 <= cfg_wdata;
        REG_A2:  coef_r.a2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || coef_wr) begin
      hv_valid_r <= '0;
    end else if (s1_adv) begin
      hv_valid_r[s1_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_chan_r <= in_channel;
      s1_idx_r  <= in_idx;
      s1_x_r    <= in_sample_in;
      s1_hv_r   <= hv_valid_r[in_idx];
      s1_byp_r  <= s1_adv && (s1_idx_r == in_idx);
      s1_bypd_r <= hist_new;
    end
    if (s1_adv) begin
      out_sample_r  <= y_sample;
      out_channel_r <= s1_chan_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_channel    = out_channel_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_idx_r) && $stable(s1_x_r)))
    else $error("Input stage changed while stalled.");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_valid_r && out_channel_r == $past(s1_chan_r)))
    else $error("Output register did not take the finished item.");

  a_hist_clear: assert property (@(posedge clk) disable iff (!rst_n)
    coef_wr |=> (hv_valid_r == '0))
    else $error("History not cleared after a coefficient write.");

  a_hist_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !coef_wr) |=> hv_valid_r[$past(s1_idx_r)])
    else $error("Written history entry not marked valid.");

endmodule

[test/biquad_filter_multichannel_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_filter_multichannel_core_test
// Checks the multichannel biquad core against a cycle-free filter model kept
// in the bench. A directed list covers identity, saturation, rounding ties,
// history feedback and ignored register writes, then random and extreme coefficient
// sets are each followed by a burst of random samples under random backpressure.
// ----------------------------------------------------------------------------
module biquad_filter_multichannel_core_test;
  import bqf_pkg::*;

  localparam int SBITS = SAMPLE_BITS_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam int ACC_W = 80;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 110;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(NUM_COEFS);
  localparam logic [CFG_IDX_W-1:0] REG_TOP = '1;

  localparam coef_t COEF_MAX = 32'sh7FFF_FFFF;
  localparam coef_t COEF_MIN = 32'sh8000_0000;
  localparam coef_t COEF_ONE = 32'sh0100_0000;
  localparam coef_t COEF_HALF = 32'sh0080_0000;
  localparam logic signed [SBITS-1:0] S_MAX = 24'sh7F_FFFF;
  localparam logic signed [SBITS-1:0] S_MIN = 24'sh80_0000;

  typedef logic signed [ACC_W-1:0] wide_t;
  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    coef_t data;
    logic [CHAN_W-1:0] chan;
    logic signed [SBITS-1:0] sample;
    bit known;
    logic signed [SBITS-1:0] want;
  } stim_row_t;

  typedef struct {
    logic signed [SBITS-1:0] sample;
    logic [CHAN_W-1:0] chan;
  } filtered_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CHAN_W-1:0] in_channel;
  logic signed [SBITS-1:0] in_sample_in;
  logic out_valid;
  logic out_ready;
  logic signed [SBITS-1:0] out_sample_out;
  logic [CHAN_W-1:0] out_channel;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  coef_t coefs [NUM_COEFS];
  logic signed [SBITS-1:0] in_hist1 [CHANNELS_DEF];
  logic signed [SBITS-1:0] in_hist2 [CHANNELS_DEF];
  hist_t out_hist1 [CHANNELS_DEF];
  hist_t out_hist2 [CHANNELS_DEF];

  filtered_t expected_q [$];
  stim_row_t script [$];
  int errors;
  int items_sent;
  int results_seen;
  bit steady_in;

  biquad_filter_multichannel_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_channel(in_channel),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_out(out_sample_out),
    .out_channel(out_channel),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic wide_t clamp(wide_t v, int w);
    wide_t top;
    top = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    if (v > top) return top;
    if (v < -top - wide_t'(1)) return -top - wide_t'(1);
    return v;
  endfunction

  function automatic void clear_history();
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      in_hist1[c] = '0;
      in_hist2[c] = '0;
      out_hist1[c] = '0;
      out_hist2[c] = '0;
    end
  endfunction

  function automatic coef_t gentle(int bits);
    coef_t v;
    v = $urandom;
    return v >>> (COEF_W - 1 - bits);
  endfunction

  // Exact sum of the five taps, rounded half up, then saturated twice.
  function automatic filtered_t filter_sample(logic [CHAN_W-1:0] ch,
                                              logic signed [SBITS-1:0] x);
    wide_t acc;
    wide_t y;
    wide_t ylim;
    filtered_t r;
    int c;
    c = ch % CHANNELS_DEF;
    acc = wide_t'(coefs[REG_B0]) * wide_t'(x)
        + wide_t'(coefs[REG_B1]) * wide_t'(in_hist1[c])
        + wide_t'(coefs[REG_B2]) * wide_t'(in_hist2[c])
        - wide_t'(coefs[REG_A1]) * wide_t'(out_hist1[c])
        - wide_t'(coefs[REG_A2]) * wide_t'(out_hist2[c])
        + (wide_t'(1) <<< (FRAC - 1));
    y = acc >>> FRAC;
    ylim = clamp(y, HIST_W);
    in_hist2[c] = in_hist1[c];
    in_hist1[c] = x;
    out_hist2[c] = out_hist1[c];
    out_hist1[c] = ylim[HIST_W-1:0];
    ylim = clamp(y, SBITS);
    r.sample = ylim[SBITS-1:0];
    r.chan = ch;
    return r;
  endfunction

  function automatic void add_sample(logic [CHAN_W-1:0] ch, logic signed [SBITS-1:0] x,
                                     bit known, logic signed [SBITS-1:0] want);
    stim_row_t row;
    row = '{ROW_SAMPLE, REG_B0, '0, ch, x, known, want};
    script.insert(script.size(), row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, coef_t data);
    stim_row_t row;
    row = '{ROW_WRITE, idx, data, '0, '0, 1'b0, '0};
    script.insert(script.size(), row);
  endfunction

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, coef_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_COEFS) begin
      coefs[idx] = data;
      clear_history();
    end
    @(posedge clk);
  endtask

  task automatic send_sample(logic [CHAN_W-1:0] ch, logic signed [SBITS-1:0] x,
                             bit known, logic signed [SBITS-1:0] want);
    filtered_t r;
    bit took;
    if (!steady_in) begin
      while ($urandom_range(99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_channel <= ch;
    in_sample_in <= x;
    do begin
      @(negedge clk);
      took = in_ready;
      if (took) begin
        r = filter_sample(ch, x);
        if (known) r.sample = want;
        expected_q.insert(expected_q.size(), r);
      end
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  initial begin
    filtered_t got;
    filtered_t want_r;
    bit take;
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      take = out_valid && out_ready;
      got.sample = out_sample_out;
      got.chan = out_channel;
      @(posedge clk);
      if (take) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction: channel %0d sample %0d",
                   $time, got.chan, got.sample);
        end else begin
          want_r = expected_q.pop_front();
          if (got.sample !== want_r.sample) begin
            errors++;
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, want_r.sample, got.sample);
          end
          if (got.chan !== want_r.chan) begin
            errors++;
            $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                     $time, want_r.chan, got.chan);
          end
        end
        if (results_seen == 200) hold = 60;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= 380 && results_seen < 500) ||
                     ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin
    coef_t coef_set [NUM_COEFS];
    logic [CHAN_W-1:0] ch;
    logic signed [SBITS-1:0] x;
    int p;
    int n;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    steady_in = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_channel <= '0;
    in_sample_in <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    coefs[REG_B0] = COEF_ONE;
    coefs[REG_B1] = '0;
    coefs[REG_B2] = '0;
    coefs[REG_A1] = '0;
    coefs[REG_A2] = '0;
    clear_history();

    // After reset the filter passes samples through unchanged.
    add_sample(0, S_MAX, 1, S_MAX);
    add_sample(7, S_MIN, 1, S_MIN);
    add_sample(1, 0, 1, 0);
    add_sample(2, 1, 1, 1);
    add_sample(3, -1, 1, -1);
    // Large gains saturate the emitted sample.
    add_write(REG_B0, COEF_MAX);
    add_sample(4, S_MAX, 1, S_MAX);
    add_sample(5, S_MIN, 1, S_MIN);
    add_sample(6, 0, 1, 0);
    add_write(REG_B0, COEF_MIN);
    add_sample(0, S_MAX, 1, S_MIN);
    add_sample(7, S_MIN, 1, S_MAX);
    // A gain of one half puts odd samples exactly halfway.
    add_write(REG_B0, COEF_HALF);
    add_sample(1, 1, 1, 1);
    add_sample(2, -1, 1, 0);
    add_sample(3, 3, 1, 2);
    add_sample(4, -3, 1, -1);
    add_write(REG_B1, COEF_HALF);
    add_write(REG_B2, -COEF_HALF);
    add_write(REG_A1, -COEF_ONE);
    add_write(REG_A2, 32'sh0040_0000);
    add_sample(5, 24'sh40_0000, 0, 0);
    add_sample(5, 24'sh12_3456, 0, 0);
    add_sample(5, -24'sh20_0000, 0, 0);
    add_sample(5, S_MAX, 0, 0);
    add_sample(6, S_MIN, 0, 0);
    add_sample(5, 24'sh0A_BCDE, 0, 0);
    // A write past the last register must leave the history alone.
    add_write(REG_SPARE, 32'hFFFF_FFFF);
    add_sample(5, 24'sh3F_FFFF, 0, 0);
    add_sample(6, -5, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        in_valid <= 1'b0;
        wait_idle();
        program_reg(script[i].idx, script[i].data);
      end else begin
        send_sample(script[i].chan, script[i].sample, script[i].known, script[i].want);
      end
    end

    ch = '0;
    for (p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_idle();
      case (p)
        0: begin
          foreach (coef_set[k]) coef_set[k] = $urandom;
        end
        1: begin
          coef_set = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
        end
        PHASES - 1: begin
          coef_set = '{COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN};
        end
        default: begin
          coef_set[REG_B0] = gentle(FRAC);
          coef_set[REG_B1] = gentle(FRAC);
          coef_set[REG_B2] = gentle(FRAC - 1);
          coef_set[REG_A1] = gentle(FRAC + 1);
          coef_set[REG_A2] = gentle(FRAC - 1);
        end
      endcase
      foreach (coef_set[k]) program_reg(CFG_IDX_W'(k), coef_set[k]);
      if (p == 3) program_reg(CFG_IDX_W'($urandom_range(REG_SPARE, REG_TOP)), $urandom);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 50) begin
          in_valid <= 1'b0;
          wait_idle();
        end
        steady_in = items_sent >= 380 && items_sent < 480;
        if ($urandom_range(99) >= 25) ch = CHAN_W'($urandom_range(0, (1 << CHAN_W) - 1));
        x = SBITS'($urandom);
        if ($urandom_range(99) < 60) x = x >>> $urandom_range(8, 20);
        send_sample(ch, x, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/bqf_pkg.sv
design/bqf_ram.sv
design/bqf_datapath.sv
design/biquad_filter_multichannel_core.sv
test/biquad_filter_multichannel_core_test.sv
